FILE: src/dlcd_pkg.sv
// Shared types and constants for the directory lookup/create/delete block.
// No dependencies; used by the top level and the checker.
`timescale 1ns / 1ps

package dlcd_pkg;

	localparam int ENTRIES  = 32;
	localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W    = $clog2(ENTRIES + 1);
	localparam int BYTE_W   = 8;
	localparam int NAME_W   = 48;
	localparam int ENTRY_W  = NAME_W + 2 * BYTE_W;
	localparam int NAME_LSB = 2 * BYTE_W;
	localparam int STAT_W   = 3;
	localparam int S_DATA_W = 56;
	localparam int M_DATA_W = 24;

	typedef enum logic [STAT_W-1:0] {
		STAT_FOUND    = 3'd0,
		STAT_CREATED  = 3'd1,
		STAT_FULL     = 3'd2,
		STAT_DELETED  = 3'd3,
		STAT_DEL_MISS = 3'd4
	} status_t;

	typedef enum logic {
		OP_OPEN   = 1'b0,
		OP_DELETE = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FIN
	} fsm_t;

endpackage

FILE: src/dlcd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module dlcd_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: src/directory_lookup_create_delete.sv
// Directory table: open/create and delete requests against a scanned entry RAM.
// Each item is handled by a one-entry-per-cycle scan of the directory RAM: a read of
// every entry, then the registered read data, scan close and finish, in that order.
// The block takes one item at a time; a new item is taken while a result waits.
// Reset (arst_n low) clears all entry valid flops at once, so every slot reads free.
// Depends on dlcd_pkg and dlcd_ram.
`timescale 1ns / 1ps

module directory_lookup_create_delete (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// [0] opcode, [48:1] file_name, [55:49] zero
	input  logic [dlcd_pkg::S_DATA_W-1:0] s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [2:0] status, [10:3] start_block, [18:11] block_count, [23:19] zero
	output logic [dlcd_pkg::M_DATA_W-1:0] m_tdata
);

	dlcd_pkg::fsm_t state_q, state_d;

	logic [dlcd_pkg::ENTRIES-1:0] used_q;
	logic [dlcd_pkg::CNT_W-1:0]   addr_q;
	logic                         rd_vld_s1;
	logic [dlcd_pkg::IDX_W-1:0]   idx_s1;

	logic                         op_q;
	logic [dlcd_pkg::NAME_W-1:0]  name_q;

	logic                         hit_q;
	logic [dlcd_pkg::IDX_W-1:0]   hit_idx_q;
	logic [dlcd_pkg::BYTE_W-1:0]  hit_start_q;
	logic [dlcd_pkg::BYTE_W-1:0]  hit_count_q;
	logic                         free_q;
	logic [dlcd_pkg::IDX_W-1:0]   free_idx_q;

	logic                          m_tvalid_q;
	logic [dlcd_pkg::STAT_W-1:0]   status_q;
	logic [dlcd_pkg::BYTE_W-1:0]   start_q;
	logic [dlcd_pkg::BYTE_W-1:0]   count_q;

	logic                          s_acc;
	logic                          issue;
	logic                          finish;
	logic                          we;
	logic [dlcd_pkg::ENTRY_W-1:0]  rdata;
	logic [dlcd_pkg::ENTRY_W-1:0]  wdata;
	logic                          ent_used;
	logic                          ent_match;

	assign s_tready = (state_q == dlcd_pkg::S_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign issue    = (state_q == dlcd_pkg::S_SCAN) && (addr_q < dlcd_pkg::CNT_W'(dlcd_pkg::ENTRIES));
	assign finish   = (state_q == dlcd_pkg::S_FIN) && (!m_tvalid_q || m_tready);

	// only a create writes the RAM; delete just drops the valid flop
	assign we    = finish && (op_q == dlcd_pkg::OP_OPEN) && !hit_q && free_q;
	assign wdata = {name_q, dlcd_pkg::BYTE_W'(0), dlcd_pkg::BYTE_W'(1)};

	dlcd_ram #(
		.WIDTH(dlcd_pkg::ENTRY_W),
		.DEPTH(dlcd_pkg::ENTRIES)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(free_idx_q),
		.wdata(wdata),
		.raddr(addr_q[dlcd_pkg::IDX_W-1:0]),
		.rdata(rdata)
	);

	assign ent_used  = used_q[idx_s1];
	assign ent_match = ent_used && (rdata[dlcd_pkg::ENTRY_W-1:dlcd_pkg::NAME_LSB] == name_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dlcd_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			dlcd_pkg::S_IDLE: begin
				if (s_acc) begin
					state_d = dlcd_pkg::S_SCAN;
				end
			end
			dlcd_pkg::S_SCAN: begin
				if (!issue && !rd_vld_s1) begin
					state_d = dlcd_pkg::S_FIN;
				end
			end
			dlcd_pkg::S_FIN: begin
				if (finish) begin
					state_d = dlcd_pkg::S_IDLE;
				end
			end
			default: state_d = dlcd_pkg::S_IDLE;
		endcase
	end

	// control: scan pointer, read pipeline, search flags, valid flops, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q     <= '0;
			addr_q     <= '0;
			rd_vld_s1  <= 1'b0;
			hit_q      <= 1'b0;
			free_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			if (s_acc) begin
				addr_q <= '0;
				hit_q  <= 1'b0;
				free_q <= 1'b0;
			end else if (issue) begin
				addr_q <= addr_q + 1'b1;
			end
			if (rd_vld_s1) begin
				if (ent_match && !hit_q) begin
					hit_q <= 1'b1;
				end
				if (!ent_used && !free_q) begin
					free_q <= 1'b1;
				end
			end
			if (finish) begin
				m_tvalid_q <= 1'b1;
				if (op_q == dlcd_pkg::OP_OPEN) begin
					if (!hit_q && free_q) begin
						used_q[free_idx_q] <= 1'b1;
					end
				end else if (hit_q) begin
					used_q[hit_idx_q] <= 1'b0;
				end
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_acc) begin
			op_q   <= s_tdata[0];
			name_q <= s_tdata[dlcd_pkg::NAME_W:1];
		end
		idx_s1 <= addr_q[dlcd_pkg::IDX_W-1:0];
		if (rd_vld_s1) begin
			if (ent_match && !hit_q) begin
				hit_idx_q   <= idx_s1;
				hit_start_q <= rdata[dlcd_pkg::BYTE_W-1:0];
				hit_count_q <= rdata[2*dlcd_pkg::BYTE_W-1:dlcd_pkg::BYTE_W];
			end
			if (!ent_used && !free_q) begin
				free_idx_q <= idx_s1;
			end
		end
		if (finish) begin
			start_q <= '0;
			count_q <= '0;
			if (op_q == dlcd_pkg::OP_OPEN) begin
				if (hit_q) begin
					status_q <= dlcd_pkg::STAT_FOUND;
					start_q  <= hit_start_q;
					count_q  <= hit_count_q;
				end else if (free_q) begin
					status_q <= dlcd_pkg::STAT_CREATED;
					start_q  <= dlcd_pkg::BYTE_W'(1);
				end else begin
					status_q <= dlcd_pkg::STAT_FULL;
				end
			end else begin
				status_q <= hit_q ? dlcd_pkg::STAT_DELETED : dlcd_pkg::STAT_DEL_MISS;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {5'd0, count_q, start_q, status_q};

endmodule

FILE: src/dlcd_checker.sv
// Port-level checks for directory_lookup_create_delete, bound to the top level.
// Depends on dlcd_pkg.
`timescale 1ns / 1ps

module dlcd_sva (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic [dlcd_pkg::S_DATA_W-1:0] s_tdata,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [dlcd_pkg::M_DATA_W-1:0] m_tdata
);

	logic [dlcd_pkg::STAT_W-1:0] st;
	assign st = m_tdata[dlcd_pkg::STAT_W-1:0];

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result item changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second item taken during a scan");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (st == dlcd_pkg::STAT_FOUND || st == dlcd_pkg::STAT_CREATED ||
			st == dlcd_pkg::STAT_FULL || st == dlcd_pkg::STAT_DELETED ||
			st == dlcd_pkg::STAT_DEL_MISS) && m_tdata[23:19] == 5'd0)
		else $error("bad status code or padding");

	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (st == dlcd_pkg::STAT_FULL || st == dlcd_pkg::STAT_DELETED ||
			st == dlcd_pkg::STAT_DEL_MISS) |-> m_tdata[18:3] == 16'd0)
		else $error("nonzero fields on a non-open result");

	a_created: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && st == dlcd_pkg::STAT_CREATED |-> m_tdata[18:3] == 16'd1)
		else $error("created entry not start 1 count 0");

endmodule

bind directory_lookup_create_delete dlcd_sva u_dlcd_sva (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.s_tdata (s_tdata),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);
